// ===== sv/assert_macros.svh =====
// Assertion helpers used by hrs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/hrs_pkg.sv =====
`default_nettype none

package hrs_pkg;

  localparam int unsigned SeqW     = 7;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned RetryW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    CMD_NEW     = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_HS_ACK  = 2'd2,
    CMD_CMD_ACK = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_HS_REQ  = 2'd1,
    KIND_CMD_PKT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_DONE_OK  = 3'd1,
    ST_HS_FAIL  = 3'd2,
    ST_CMD_FAIL = 3'd3,
    ST_BUSY     = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_RETRY     = 2'd1,
    CFG_SEQ_START = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  localparam logic [TimeoutW-1:0] TimeoutReset  = 16'd100;
  localparam logic [RetryW-1:0]   RetryReset    = 4'd3;
  localparam logic [SeqW-1:0]     SeqStartReset = 7'd0;

  typedef struct packed {
    kind_e              send_kind;
    logic [SeqW-1:0]    send_seq;
    logic [ByteW-1:0]   send_type;
    logic [ByteW-1:0]   send_code;
    status_e            status;
    logic               busy_res;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/hrs_if.sv =====
`default_nettype none

interface hrs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] command_type;
  logic [7:0] command_code;

  modport source (output valid, output cmd, output command_type, output command_code,
                  input ready);
  modport sink   (input valid, input cmd, input command_type, input command_code,
                  output ready);
endinterface

interface hrs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] send_kind;
  logic [6:0] send_seq;
  logic [7:0] send_type;
  logic [7:0] send_code;
  logic [2:0] status;
  logic       busy_res;

  modport source (output valid, output send_kind, output send_seq, output send_type,
                  output send_code, output status, output busy_res, input ready);
  modport sink   (input valid, input send_kind, input send_seq, input send_type,
                  input send_code, input status, input busy_res, output ready);
endinterface

`default_nettype wire

// ===== sv/handshake_retry_sender_top.sv =====
// Stop-and-wait sender with two phases: handshake, then command.
// The input channel carries events: a new command (with type and code bytes),
// a timer tick, a handshake acknowledge or a command acknowledge. Every accepted
// event yields exactly one result on the output channel, which says what to send
// (nothing, a handshake request or the held command packet), a status code and
// whether a transaction is still in progress.
// The state update is computed from the event in the cycle it is accepted and
// the result lands in the output register at that edge.
// Throughput is one event per cycle unless the receiver stalls; the only storage
// in the path is the single output register, which is the limit on how many
// results can wait. When the receiver stalls, the output register holds its
// result and the input stops accepting until that result has been transferred;
// a result can be taken and a new event accepted in the same cycle.
// Reset (rst_ni low, asynchronous) puts the block idle with no result pending,
// timeout 100 ticks, retry limit 3 and sequence number 0.
// The configuration port writes timeout_ticks, retry_limit or seq_start; a
// seq_start write also loads the running sequence number. Writes must be made
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module handshake_retry_sender_top import hrs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  hrs_in_if.sink                   in_s,
  hrs_out_if.source                out_s,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAIT_HS  = 2'd1,
    PH_WAIT_CMD = 2'd2
  } phase_e;

  // Configuration registers.
  logic [TimeoutW-1:0] timeout_q;
  logic [RetryW-1:0]   retry_q;

  // Transaction state.
  phase_e              phase_q, phase_d;
  logic [RetryW-1:0]   attempts_q, attempts_d;
  logic [TimeoutW-1:0] elapsed_q, elapsed_d;
  logic [SeqW-1:0]     seq_q, seq_d;
  logic                hs_seen_q, hs_seen_d;
  logic                cmd_seen_q, cmd_seen_d;
  // Held command bytes are payload and are only read after a new command wrote them.
  logic [ByteW-1:0]    held_type_q, held_type_d;
  logic [ByteW-1:0]    held_code_q, held_code_d;

  // Output register.
  logic                out_valid_q;
  result_t             res_q, res_d;

  logic                in_fire;
  logic                out_fire;
  cmd_e                cmd;
  logic [TimeoutW-1:0] elapsed_inc;
  kind_e               kind;
  status_e             status;

  assign out_fire   = out_valid_q && out_s.ready;
  // A new event may enter whenever the output register is free or drains this cycle.
  assign in_s.ready = !out_valid_q || out_s.ready;
  assign in_fire    = in_s.valid && in_s.ready;
  assign cmd        = cmd_e'(in_s.cmd);

  // The elapsed count saturates at its maximum.
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    attempts_d  = attempts_q;
    elapsed_d   = elapsed_q;
    seq_d       = seq_q;
    hs_seen_d   = hs_seen_q;
    cmd_seen_d  = cmd_seen_q;
    held_type_d = held_type_q;
    held_code_d = held_code_q;
    kind        = KIND_NONE;
    status      = ST_NONE;

    if (cmd == CMD_NEW) begin
      if (phase_q != PH_IDLE) begin
        status = ST_BUSY;
      end else begin
        held_type_d = in_s.command_type;
        held_code_d = in_s.command_code;
        phase_d     = PH_WAIT_HS;
        attempts_d  = RetryW'(1);
        elapsed_d   = '0;
        kind        = KIND_HS_REQ;
      end
    end else begin
      // Acknowledges are sticky; a flag is consumed only while waiting in its phase.
      if (cmd == CMD_HS_ACK) begin
        hs_seen_d = 1'b1;
      end
      if (cmd == CMD_CMD_ACK) begin
        cmd_seen_d = 1'b1;
      end

      if (phase_q == PH_WAIT_HS && hs_seen_d) begin
        hs_seen_d  = 1'b0;
        phase_d    = PH_WAIT_CMD;
        attempts_d = RetryW'(1);
        elapsed_d  = '0;
        kind       = KIND_CMD_PKT;
      end else if (phase_q == PH_WAIT_CMD && cmd_seen_d) begin
        cmd_seen_d = 1'b0;
        phase_d    = PH_IDLE;
        attempts_d = '0;
        elapsed_d  = '0;
        seq_d      = seq_q + 1'b1;
        status     = ST_DONE_OK;
      end else if (phase_q != PH_IDLE && cmd == CMD_TICK) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= timeout_q) begin
          if (attempts_q < retry_q) begin
            // Timeout with attempts left: resend the packet of this phase.
            attempts_d = attempts_q + 1'b1;
            elapsed_d  = '0;
            kind       = (phase_q == PH_WAIT_HS) ? KIND_HS_REQ : KIND_CMD_PKT;
          end else begin
            status     = (phase_q == PH_WAIT_HS) ? ST_HS_FAIL : ST_CMD_FAIL;
            phase_d    = PH_IDLE;
            attempts_d = '0;
            elapsed_d  = '0;
            seq_d      = seq_q + 1'b1;
          end
        end
      end
    end

    res_d.send_kind = kind;
    res_d.send_seq  = (kind != KIND_NONE) ? seq_q : '0;
    res_d.send_type = (kind == KIND_CMD_PKT) ? held_type_d : '0;
    res_d.send_code = (kind == KIND_CMD_PKT) ? held_code_d : '0;
    res_d.status    = status;
    res_d.busy_res  = (phase_d != PH_IDLE);
  end

  // Control state, configuration and the output valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutReset;
      retry_q     <= RetryReset;
      phase_q     <= PH_IDLE;
      attempts_q  <= '0;
      elapsed_q   <= '0;
      seq_q       <= SeqStartReset;
      hs_seen_q   <= 1'b0;
      cmd_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q    <= phase_d;
        attempts_q <= attempts_d;
        elapsed_q  <= elapsed_d;
        seq_q      <= seq_d;
        hs_seen_q  <= hs_seen_d;
        cmd_seen_q <= cmd_seen_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TIMEOUT:   timeout_q <= cfg_data_i[TimeoutW-1:0];
          CFG_RETRY:     retry_q   <= cfg_data_i[RetryW-1:0];
          CFG_SEQ_START: seq_q     <= cfg_data_i[SeqW-1:0];
          default:       ;
        endcase
      end
    end
  end

  // Payload registers: held bytes and the result.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      held_type_q <= held_type_d;
      held_code_q <= held_code_d;
      res_q       <= res_d;
    end
  end

  assign out_s.valid     = out_valid_q;
  assign out_s.send_kind = res_q.send_kind;
  assign out_s.send_seq  = res_q.send_seq;
  assign out_s.send_type = res_q.send_type;
  assign out_s.send_code = res_q.send_code;
  assign out_s.status    = res_q.status;
  assign out_s.busy_res  = res_q.busy_res;

endmodule

`default_nettype wire

// ===== sv/hrs_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module hrs_checker import hrs_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] out_send_kind_i,
  input wire logic [6:0] out_send_seq_i,
  input wire logic [7:0] out_send_type_i,
  input wire logic [2:0] out_status_i,
  input wire logic       out_busy_res_i
);

  logic out_fire;
  logic out_sends;
  logic out_silent;
  logic out_rejects;
  logic out_finishes;
  logic out_stalled;

  assign out_fire     = out_valid_i && out_ready_i;
  assign out_sends    = out_fire && (out_send_kind_i != KIND_NONE);
  assign out_silent   = out_fire && (out_send_kind_i == KIND_NONE);
  assign out_rejects  = out_fire && (out_status_i == ST_BUSY);
  assign out_finishes = out_fire && (out_status_i == ST_DONE_OK ||
                                     out_status_i == ST_HS_FAIL ||
                                     out_status_i == ST_CMD_FAIL);
  assign out_stalled  = out_valid_i && !out_ready_i;

  // A send never comes with a status report.
  `ASSERT_IMPLIES(a_send_no_status, out_sends, out_status_i == ST_NONE)

  // A rejected command leaves the transaction in progress.
  `ASSERT_IMPLIES(a_busy_keeps_busy, out_rejects, out_busy_res_i)

  // Success or failure ends the transaction.
  `ASSERT_IMPLIES(a_finish_idle, out_finishes, !out_busy_res_i)

  // Nothing sent means zeroed sequence and type fields.
  `ASSERT_IMPLIES(a_idle_fields_zero, out_silent, out_send_seq_i == '0 && out_send_type_i == '0)

  // A stalled result stays put.
  `ASSERT_NEXT(a_stall_hold, out_stalled, out_valid_i && $stable({out_send_kind_i, out_status_i}))

endmodule

bind handshake_retry_sender_top hrs_checker u_hrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_s.valid),
  .out_ready_i    (out_s.ready),
  .out_send_kind_i(out_s.send_kind),
  .out_send_seq_i (out_s.send_seq),
  .out_send_type_i(out_s.send_type),
  .out_status_i   (out_s.status),
  .out_busy_res_i (out_s.busy_res)
);

`default_nettype wire

// ===== sim/retry_sender_checker.sv =====
`default_nettype none

// Watches both channels of the sender, predicts every result from the accepted
// events and compares each result transfer with the oldest prediction.
module retry_sender_checker import hrs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  hrs_in_if                        in_mon,
  hrs_out_if                       out_mon,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output logic                     busy_o,
  output logic                     wait_hs_o
);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAIT_HS  = 2'd1,
    PH_WAIT_CMD = 2'd2
  } phase_e;

  logic [TimeoutW-1:0] timeout_ticks;
  logic [RetryW-1:0]   retry_limit;

  phase_e              phase;
  logic [RetryW-1:0]   attempts;
  logic [TimeoutW-1:0] elapsed;
  logic [SeqW-1:0]     seq_number;
  logic                hs_ack_seen;
  logic                cmd_ack_seen;
  logic [ByteW-1:0]    held_type;
  logic [ByteW-1:0]    held_code;

  result_t     expected_sends[$];
  int unsigned mismatches = 0;
  int unsigned waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;
  assign busy_o       = (phase != PH_IDLE);
  assign wait_hs_o    = (phase == PH_WAIT_HS);

  // Every finished transaction, good or failed, moves on to the next sequence number.
  function automatic void close_transaction();
    phase      = PH_IDLE;
    attempts   = '0;
    elapsed    = '0;
    seq_number = seq_number + 1'b1;
  endfunction

  function automatic result_t advance_sender(cmd_e ev, logic [ByteW-1:0] ev_type,
                                             logic [ByteW-1:0] ev_code);
    result_t r;
    r           = '0;
    r.send_kind = KIND_NONE;
    r.status    = ST_NONE;
    if (ev == CMD_NEW) begin
      if (phase != PH_IDLE) begin
        r.status = ST_BUSY;
      end else begin
        held_type   = ev_type;
        held_code   = ev_code;
        phase       = PH_WAIT_HS;
        attempts    = 4'd1;
        elapsed     = '0;
        r.send_kind = KIND_HS_REQ;
      end
    end else begin
      if (ev == CMD_HS_ACK) hs_ack_seen = 1'b1;
      if (ev == CMD_CMD_ACK) cmd_ack_seen = 1'b1;
      // A pending acknowledge is taken before the timer is looked at.
      if (phase == PH_WAIT_HS && hs_ack_seen) begin
        hs_ack_seen = 1'b0;
        phase       = PH_WAIT_CMD;
        attempts    = 4'd1;
        elapsed     = '0;
        r.send_kind = KIND_CMD_PKT;
      end else if (phase == PH_WAIT_CMD && cmd_ack_seen) begin
        cmd_ack_seen = 1'b0;
        r.status     = ST_DONE_OK;
        close_transaction();
      end else if (phase != PH_IDLE && ev == CMD_TICK) begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
        if (elapsed >= timeout_ticks) begin
          if (attempts < retry_limit) begin
            attempts    = attempts + 1'b1;
            elapsed     = '0;
            r.send_kind = (phase == PH_WAIT_HS) ? KIND_HS_REQ : KIND_CMD_PKT;
          end else begin
            r.status = (phase == PH_WAIT_HS) ? ST_HS_FAIL : ST_CMD_FAIL;
            close_transaction();
          end
        end
      end
    end
    if (r.send_kind != KIND_NONE) r.send_seq = seq_number;
    if (r.send_kind == KIND_CMD_PKT) begin
      r.send_type = held_type;
      r.send_code = held_code;
    end
    r.busy_res = (phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, logic [ByteW-1:0] want,
                                      logic [ByteW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      timeout_ticks = TimeoutReset;
      retry_limit   = RetryReset;
      phase         = PH_IDLE;
      attempts      = '0;
      elapsed       = '0;
      seq_number    = SeqStartReset;
      hs_ack_seen   = 1'b0;
      cmd_ack_seen  = 1'b0;
      held_type     = '0;
      held_code     = '0;
      expected_sends.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TIMEOUT:   timeout_ticks = cfg_data_i[TimeoutW-1:0];
          CFG_RETRY:     retry_limit = cfg_data_i[RetryW-1:0];
          CFG_SEQ_START: seq_number = cfg_data_i[SeqW-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_sends.size() == 0) begin
          $error("result transfer with no event waiting for it");
          mismatches++;
        end else begin
          want = expected_sends.pop_front();
          check_field("send_kind", ByteW'(want.send_kind), ByteW'(out_mon.send_kind));
          check_field("send_seq", ByteW'(want.send_seq), ByteW'(out_mon.send_seq));
          check_field("send_type", want.send_type, out_mon.send_type);
          check_field("send_code", want.send_code, out_mon.send_code);
          check_field("status", ByteW'(want.status), ByteW'(out_mon.status));
          check_field("busy_res", ByteW'(want.busy_res), ByteW'(out_mon.busy_res));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_sends.push_back(advance_sender(cmd_e'(in_mon.cmd), in_mon.command_type,
                                                in_mon.command_code));
      end
    end
    waiting = expected_sends.size();
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

// Stimulus and verdict for the stop-and-wait sender. The checker beside the
// block does all of the predicting and comparing; this module only produces
// events, configuration writes and backpressure, and decides pass or fail.
module tb_top;
  import hrs_pkg::*;

  // Quiet cycles (no transfer on either channel) before the run is declared hung.
  // The longest legitimate quiet stretch is a short settle pause or a run of
  // random stalls at 85 percent, both far below this.
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned ItemTarget = 500;
  localparam int unsigned Segments   = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hrs_in_if  in_ch ();
  hrs_out_if out_ch ();

  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  logic        txn_busy;
  logic        txn_wait_hs;

  // Idle and stall odds in percent; changed between phases of the run.
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  // Shadow of the timer settings, used only to size the tick runs so that
  // retries and failures are actually reached.
  int unsigned cur_timeout = 32'(TimeoutReset);
  int unsigned cur_retry = 32'(RetryReset);
  int unsigned sent_items = 0;
  int unsigned quiet_cycles = 0;

  // Settings of the random phases: fastest timeouts, zero values, the largest
  // timeout and retry limit, and a wrap of the sequence number from 127.
  int unsigned seg_ticks[Segments] = '{1, 0, 3, 65535, 2, 1, 4, 2};
  int unsigned seg_retry[Segments] = '{1, 0, 15, 15, 3, 2, 1, 4};
  int unsigned seg_seq[Segments]   = '{127, 0, 64, 127, 5, 99, 0, 126};
  int unsigned src_idle_by_mode[4]   = '{0, 85, 0, 34};
  int unsigned sink_stall_by_mode[4] = '{0, 0, 85, 34};

  always #5 clk_i = ~clk_i;

  handshake_retry_sender_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_ch),
    .out_s      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  retry_sender_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .busy_o       (txn_busy),
    .wait_hs_o    (txn_wait_hs)
  );

  // The receiver decides at every falling edge whether it takes a result in
  // the next cycle.
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("[handshake_retry_sender_top] ERROR");
          $finish;
        end
      end
    end
  end

  function automatic logic [ByteW-1:0] rand_byte();
    return ByteW'($urandom);
  endfunction

  // Offers one event and returns at the falling edge after its transfer. The
  // random gap in front of the event is how the event source goes idle.
  task automatic send_event(cmd_e ev, logic [ByteW-1:0] ev_type, logic [ByteW-1:0] ev_code);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        = 1'b1;
    in_ch.cmd          = ev;
    in_ch.command_type = ev_type;
    in_ch.command_code = ev_code;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    sent_items++;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  // Brings the block back to idle before a configuration write: every result
  // must have arrived, and an open transaction is closed with the acknowledge
  // its current phase is waiting for.
  task automatic settle();
    wait_drained();
    while (txn_busy) begin
      send_event(txn_wait_hs ? CMD_HS_ACK : CMD_CMD_ACK, rand_byte(), rand_byte());
      wait_drained();
    end
    // Every event yields a result, so nothing is left in flight at this point
    // and the pause below is only a margin.
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic apply_settings(int unsigned ticks, int unsigned retries, int unsigned seq0);
    settle();
    write_reg(CFG_TIMEOUT, CfgDataW'(ticks));
    write_reg(CFG_RETRY, CfgDataW'(retries));
    write_reg(CFG_SEQ_START, CfgDataW'(seq0));
    cur_timeout = ticks;
    cur_retry   = retries;
  endtask

  // Mostly timer ticks, with an occasional new command that lands on a busy
  // sender and must be rejected.
  task automatic tick_or_intrude();
    if ($urandom_range(99) < 8) begin
      send_event(CMD_NEW, rand_byte(), rand_byte());
    end else begin
      send_event(CMD_TICK, 8'h00, 8'h00);
    end
  endtask

  // One well-formed transaction with random content: a new command, a random run
  // of up to 40 ticks that can reach retries and failures, the handshake
  // acknowledge, more ticks and the command acknowledge. Acknowledges are
  // sometimes dropped so that the timeout paths are taken too.
  task automatic run_transaction();
    int unsigned span;
    span = ((cur_retry == 0) ? 1 : cur_retry) * cur_timeout + 2;
    if (span > 40) span = 40;
    send_event(CMD_NEW, rand_byte(), rand_byte());
    repeat ($urandom_range(0, span)) tick_or_intrude();
    if ($urandom_range(99) < 85) send_event(CMD_HS_ACK, rand_byte(), rand_byte());
    repeat ($urandom_range(0, span)) tick_or_intrude();
    if ($urandom_range(99) < 85) send_event(CMD_CMD_ACK, rand_byte(), rand_byte());
  endtask

  initial begin
    int unsigned seg_end;
    int unsigned mode;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_TICK;
    in_ch.command_type = '0;
    in_ch.command_code = '0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_TIMEOUT;
    cfg_data           = '0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, first under the reset settings (timeout 100, three
    // attempts, sequence 0). A full transaction with all-zero bytes and a busy
    // rejection carrying all-one bytes.
    send_event(CMD_NEW, 8'h00, 8'h00);
    send_event(CMD_NEW, 8'hFF, 8'hFF);
    send_event(CMD_TICK, 8'h00, 8'h00);
    send_event(CMD_HS_ACK, 8'h00, 8'h00);
    // A handshake acknowledge while waiting for the command acknowledge stays
    // pending and is taken by the next transaction at its first tick, ahead of
    // any timeout.
    send_event(CMD_HS_ACK, 8'h00, 8'h00);
    send_event(CMD_CMD_ACK, 8'h00, 8'h00);
    send_event(CMD_NEW, 8'hFF, 8'hFF);
    send_event(CMD_TICK, 8'h00, 8'h00);
    send_event(CMD_CMD_ACK, 8'h00, 8'h00);
    // A command acknowledge while idle is kept and finishes the next command
    // phase at its first event.
    send_event(CMD_CMD_ACK, 8'h00, 8'h00);
    send_event(CMD_NEW, 8'hA5, 8'h5A);
    send_event(CMD_HS_ACK, 8'h00, 8'h00);
    send_event(CMD_TICK, 8'h00, 8'h00);

    // Single-tick timeout and two attempts: a resend, then a failed handshake;
    // then a resent command packet and a failed command. The sequence number
    // goes from 126 through 127 and wraps to zero.
    apply_settings(1, 2, 126);
    send_event(CMD_NEW, 8'h5A, 8'hA5);
    send_event(CMD_TICK, 8'h00, 8'h00);
    send_event(CMD_TICK, 8'h00, 8'h00);
    send_event(CMD_NEW, 8'hFF, 8'h00);
    send_event(CMD_HS_ACK, 8'h00, 8'h00);
    send_event(CMD_TICK, 8'h00, 8'h00);
    send_event(CMD_TICK, 8'h00, 8'h00);

    // A zero timeout expires at every tick and a zero retry limit allows just
    // the first attempt, so each phase fails at its first tick.
    apply_settings(0, 0, 0);
    send_event(CMD_NEW, 8'h3C, 8'hC3);
    send_event(CMD_TICK, 8'h00, 8'h00);
    send_event(CMD_NEW, 8'h0F, 8'hF0);
    send_event(CMD_HS_ACK, 8'h00, 8'h00);
    send_event(CMD_TICK, 8'h00, 8'h00);

    // Random part: each segment has its own timer settings and one of the four
    // idling modes, so every mode is seen with two settings.
    for (int unsigned seg = 0; seg < Segments; seg++) begin
      apply_settings(seg_ticks[seg], seg_retry[seg], seg_seq[seg]);
      mode           = seg % 4;
      src_idle_pct   = src_idle_by_mode[mode];
      sink_stall_pct = sink_stall_by_mode[mode];
      seg_end        = sent_items + (ItemTarget - 25) / Segments;
      while (sent_items < seg_end) begin
        if ($urandom_range(99) < 80) begin
          run_transaction();
        end else begin
          // Loose events in any order, including acknowledges nobody asked for.
          send_event(cmd_e'($urandom_range(3)), rand_byte(), rand_byte());
        end
      end
    end

    // Let the receiver drain everything that is still owed, then pause so that
    // a stray result can still show up.
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[handshake_retry_sender_top] OK");
    end else begin
      $display("[handshake_retry_sender_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/hrs_pkg.sv
sv/hrs_if.sv
sv/handshake_retry_sender_top.sv
sv/hrs_checker.sv
sim/retry_sender_checker.sv
sim/tb_top.sv
